### rtl/spc_pkg.sv
// shared types and constants of the spectrogram pixel colormap
package spc_pkg;

    localparam int CHAN_W  = 8;
    localparam int SHIFT_W = 5;

    typedef logic [CHAN_W-1:0]  chan_t;
    typedef logic [SHIFT_W-1:0] shift_t;

    typedef struct packed
    {
        chan_t red;
        chan_t green;
        chan_t blue;
    } pixel_t;

    localparam shift_t SHIFT_RESET = 5'd10;
    localparam chan_t  CHAN_MAX    = 8'hFF;
    localparam chan_t  ALPHA_OPAQUE = 8'hFF;

endpackage

### rtl/spectrogram_pixel_colormap.sv
// top level: spectrum magnitude to opaque rgb pixel through two square root chains
//
// channel   direction  handshake             payload
// in        input      in_valid / in_stall   magnitude
// out       output     out_valid / out_stall red, green, blue, alpha
// cfg       input      cfg_valid / cfg_ready cfg_data (normalize_shift)
//
// one item per cycle sustained while in_stall is low; the pipeline is the input register,
// the two bit-per-cell square root chains (FRAC_BITS+2 and FRAC_BITS+1 cells), three
// color stages and the output register
// the whole pipeline advances together; a one-entry skid behind the output
// register catches the item in flight when out_stall is seen, and in_stall is that
// skid being full
// rst_n clears valids and loads normalize_shift with 10; cfg_ready is always high
module spectrogram_pixel_colormap
    import spc_pkg::*;
#(
    parameter int MAG_BITS  = 24,
    parameter int FRAC_BITS = 12
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [MAG_BITS-1:0] magnitude,
    output logic                out_valid,
    input  logic                out_stall,
    output chan_t               red,
    output chan_t               green,
    output chan_t               blue,
    output chan_t               alpha,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  shift_t              cfg_data
);

    localparam int MW = MAG_BITS + FRAC_BITS;   // shifted magnitude width
    localparam int HW = FRAC_BITS + 3;          // clamped m width
    localparam int N1 = FRAC_BITS + 2;          // root bits of v
    localparam int N2 = FRAC_BITS + 1;          // root bits of w
    localparam logic [MW-1:0] LIMIT = MW'(1) << (FRAC_BITS + 2);

    // configuration
    shift_t shift_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= SHIFT_RESET;
        end
        else if (cfg_valid)
        begin
            shift_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;

    // pipeline advance, held only while the skid holds an item
    logic en;
    logic skid_valid_reg;
    logic skid_valid_next;

    assign en       = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    // normalize and clamp
    logic [MW-1:0] m_full;
    logic [HW-1:0] m_next;
    logic [HW-1:0] m_reg;
    logic          front_valid_reg;

    always_comb
    begin
        m_full = {magnitude, {FRAC_BITS{1'b0}}} >> shift_reg;
        if (m_full > LIMIT)
        begin
            m_next = LIMIT[HW-1:0];
        end
        else
        begin
            m_next = m_full[HW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            front_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg <= m_next;
        end
    end

    // v = isqrt(m << F)
    logic          v_valid;
    logic [N1-1:0] v_root;

    spc_sqrt_chain #(.N(N1)) u_sqrt_v
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .valid_i (front_valid_reg),
        .rad_i   ({1'b0, m_reg, {FRAC_BITS{1'b0}}}),
        .valid_o (v_valid),
        .rad_o   (),
        .root_o  (v_root)
    );

    // w = isqrt(v << F); v rides along in the radicand
    logic            w_valid;
    logic [2*N2-1:0] w_rad;
    logic [N2-1:0]   w_root;

    spc_sqrt_chain #(.N(N2)) u_sqrt_w
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .valid_i (v_valid),
        .rad_i   ({v_root, {FRAC_BITS{1'b0}}}),
        .valid_o (w_valid),
        .rad_o   (w_rad),
        .root_o  (w_root)
    );

    // color stages, three per channel
    logic [N1-1:0] v_late;
    logic [2:0]    col_valid_reg;
    pixel_t        pix;

    assign v_late = w_rad[2*N2-1:FRAC_BITS];

    spc_hue_cell #(.FRAC_BITS(FRAC_BITS), .PHASE(1)) u_red
    (
        .clk  (clk),
        .en   (en),
        .v    (v_late),
        .w    (w_root),
        .chan (pix.red)
    );

    spc_hue_cell #(.FRAC_BITS(FRAC_BITS), .PHASE(0)) u_green
    (
        .clk  (clk),
        .en   (en),
        .v    (v_late),
        .w    (w_root),
        .chan (pix.green)
    );

    spc_hue_cell #(.FRAC_BITS(FRAC_BITS), .PHASE(-1)) u_blue
    (
        .clk  (clk),
        .en   (en),
        .v    (v_late),
        .w    (w_root),
        .chan (pix.blue)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_valid_reg <= '0;
        end
        else if (en)
        begin
            col_valid_reg <= {col_valid_reg[1:0], w_valid};
        end
    end

    // output register plus one-entry skid
    logic   take;
    logic   pipe_valid;
    logic   out_valid_reg;
    logic   out_valid_next;
    pixel_t out_pix_reg;
    pixel_t out_pix_next;
    pixel_t skid_pix_reg;
    pixel_t skid_pix_next;

    assign pipe_valid = col_valid_reg[2];
    assign take       = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_pix_next    = out_pix_reg;
        skid_valid_next = skid_valid_reg;
        skid_pix_next   = skid_pix_reg;
        if (take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_pix_next    = skid_pix_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = pipe_valid;
                out_pix_next   = pix;
            end
        end
        else if (pipe_valid && en)
        begin
            // output is held, park the item leaving the pipeline
            skid_valid_next = 1'b1;
            skid_pix_next   = pix;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_pix_reg  <= out_pix_next;
        skid_pix_reg <= skid_pix_next;
    end

    assign out_valid = out_valid_reg;
    assign red       = out_pix_reg.red;
    assign green     = out_pix_reg.green;
    assign blue      = out_pix_reg.blue;
    assign alpha     = ALPHA_OPAQUE;

endmodule

### rtl/spc_sqrt_cell.sv
// one restoring square root cell, settles one root bit per stage
module spc_sqrt_cell
    import spc_pkg::*;
#(
    parameter int N = 14,
    parameter int K = 0
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           valid_i,
    input  logic [2*N-1:0] rad_i,
    input  logic [N:0]     rem_i,
    input  logic [N-1:0]   root_i,
    output logic           valid_o,
    output logic [2*N-1:0] rad_o,
    output logic [N:0]     rem_o,
    output logic [N-1:0]   root_o
);

    localparam int PAIR_LSB = 2 * (N - 1 - K);

    logic           valid_reg;
    logic [2*N-1:0] rad_reg;
    logic [N:0]     rem_reg;
    logic [N-1:0]   root_reg;
    logic [N:0]     rem_next;
    logic [N-1:0]   root_next;
    logic [N+2:0]   rem_part;
    logic [N+2:0]   trial;
    logic [N+2:0]   diff;

    always_comb
    begin
        rem_part = {rem_i, rad_i[PAIR_LSB +: 2]};
        trial    = {1'b0, root_i, 2'b01};
        diff     = rem_part - trial;
        if (rem_part >= trial)
        begin
            rem_next  = diff[N:0];
            root_next = {root_i[N-2:0], 1'b1};
        end
        else
        begin
            rem_next  = rem_part[N:0];
            root_next = {root_i[N-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= rad_i;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign valid_o = valid_reg;
    assign rad_o   = rad_reg;
    assign rem_o   = rem_reg;
    assign root_o  = root_reg;

endmodule

### rtl/spc_sqrt_chain.sv
// row of square root cells, radicand travels along unshifted
module spc_sqrt_chain
    import spc_pkg::*;
#(
    parameter int N = 14
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           valid_i,
    input  logic [2*N-1:0] rad_i,
    output logic           valid_o,
    output logic [2*N-1:0] rad_o,
    output logic [N-1:0]   root_o
);

    logic           valid_w [N+1];
    logic [2*N-1:0] rad_w   [N+1];
    logic [N:0]     rem_w   [N];
    logic [N-1:0]   root_w  [N+1];

    assign valid_w[0] = valid_i;
    assign rad_w[0]   = rad_i;
    assign rem_w[0]   = '0;
    assign root_w[0]  = '0;

    for (genvar k = 0; k < N; k++)
    begin : g_cell
        if (k == N - 1)
        begin : g_last
            spc_sqrt_cell #(.N(N), .K(k)) u_cell
            (
                .clk     (clk),
                .rst_n   (rst_n),
                .en      (en),
                .valid_i (valid_w[k]),
                .rad_i   (rad_w[k]),
                .rem_i   (rem_w[k]),
                .root_i  (root_w[k]),
                .valid_o (valid_w[k+1]),
                .rad_o   (rad_w[k+1]),
                .rem_o   (),
                .root_o  (root_w[k+1])
            );
        end
        else
        begin : g_mid
            spc_sqrt_cell #(.N(N), .K(k)) u_cell
            (
                .clk     (clk),
                .rst_n   (rst_n),
                .en      (en),
                .valid_i (valid_w[k]),
                .rad_i   (rad_w[k]),
                .rem_i   (rem_w[k]),
                .root_i  (root_w[k]),
                .valid_o (valid_w[k+1]),
                .rad_o   (rad_w[k+1]),
                .rem_o   (rem_w[k+1]),
                .root_o  (root_w[k+1])
            );
        end
    end

    assign valid_o = valid_w[N];
    assign rad_o   = rad_w[N];
    assign root_o  = root_w[N];

endmodule

### rtl/spc_hue_cell.sv
// one color channel: hue ramp, scale by w, byte conversion with saturation
module spc_hue_cell
    import spc_pkg::*;
#(
    parameter int FRAC_BITS = 12,
    parameter int PHASE     = 0
)
(
    input  logic                 clk,
    input  logic                 en,
    input  logic [FRAC_BITS+1:0] v,
    input  logic [FRAC_BITS:0]   w,
    output chan_t                chan
);

    localparam int    TW     = FRAC_BITS + 4;
    localparam int    CW     = FRAC_BITS + 1;
    localparam int    SW     = 2 * CW - FRAC_BITS;
    localparam longint ONE_I = longint'(1) << FRAC_BITS;
    localparam logic signed [TW-1:0] ONE        = TW'(ONE_I);
    localparam logic signed [TW-1:0] SIXTH      = TW'(ONE_I / 6);
    localparam logic signed [TW-1:0] HALF       = TW'(ONE_I / 2);
    localparam logic signed [TW-1:0] TWO_THIRDS = TW'((2 * ONE_I) / 3);
    localparam logic signed [TW-1:0] OFFSET     = TW'(longint'(PHASE) * (ONE_I / 3));

    logic signed [TW-1:0] t0;
    logic signed [TW-1:0] t1;
    logic signed [TW-1:0] t2;
    logic signed [TW-1:0] ramp;
    logic signed [TW-1:0] c_wide;
    logic [CW-1:0]        c_reg;
    logic [CW-1:0]        w_reg;
    logic [2*CW-1:0]      prod_reg;
    logic [2*CW-1:0]      prod_next;
    logic [SW-1:0]        scaled;
    logic [SW+7:0]        times_255;
    logic [SW+7-FRAC_BITS:0] byte_wide;
    chan_t                byte_next;
    chan_t                byte_reg;

    // phase shift with a single wrap into range
    always_comb
    begin
        t0 = signed'({2'b00, v}) + OFFSET;
        t1 = (t0 < 0) ? t0 + ONE : t0;
        t2 = (t1 > ONE) ? t1 - ONE : t1;
        if (t2 < SIXTH)
        begin
            ramp = t2;
        end
        else
        begin
            ramp = TWO_THIRDS - t2;
        end
        if (t2 < SIXTH || (t2 >= HALF && t2 < TWO_THIRDS))
        begin
            c_wide = (ramp <<< 2) + (ramp <<< 1);
        end
        else if (t2 < HALF)
        begin
            c_wide = ONE;
        end
        else
        begin
            c_wide = '0;
        end
    end

    assign prod_next = {{CW{1'b0}}, c_reg} * {{CW{1'b0}}, w_reg};

    // scaled * 255 >> F, clipped to a byte
    always_comb
    begin
        scaled    = prod_reg[2*CW-1:FRAC_BITS];
        times_255 = {scaled, 8'b0} - {8'b0, scaled};
        byte_wide = times_255[SW+7:FRAC_BITS];
        if (byte_wide > (SW+8-FRAC_BITS)'(CHAN_MAX))
        begin
            byte_next = CHAN_MAX;
        end
        else
        begin
            byte_next = byte_wide[CHAN_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg    <= c_wide[CW-1:0];
            w_reg    <= w;
            prod_reg <= prod_next;
            byte_reg <= byte_next;
        end
    end

    assign chan = byte_reg;

endmodule

### rtl/spc_checker.sv
// port-level checks of the colormap and their bind to the top level
module spc_checker
    import spc_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  in_valid,
    input logic  in_stall,
    input logic  out_valid,
    input logic  out_stall,
    input chan_t red,
    input chan_t green,
    input chan_t blue,
    input chan_t alpha
);

    // input only backs up behind a held output transfer
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall))
        else $error("in_stall rose without a held output");

    a_stall_has_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("in_stall with empty output");

    a_stall_release: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall && !out_stall |=> !in_stall)
        else $error("skid not drained after output transfer");

    a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> alpha == ALPHA_OPAQUE)
        else $error("pixel not opaque");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(red) && $stable(green)
            && $stable(blue))
        else $error("stalled pixel changed");

endmodule

bind spectrogram_pixel_colormap spc_checker u_spc_checker (.*);

### bench/pixel_checker.sv
// checker for the spectrogram colormap: predicts each pixel and compares it at the output
`timescale 1ns / 100ps

module pixel_checker
    import spc_pkg::*;
#(
    parameter int MAG_BITS  = 24,
    parameter int FRAC_BITS = 12
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [MAG_BITS-1:0] magnitude,
    input  logic                out_valid,
    input  logic                out_stall,
    input  chan_t               red,
    input  chan_t               green,
    input  chan_t               blue,
    input  chan_t               alpha,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  shift_t              cfg_data,
    output int                  mismatch_count,
    output int                  pixels_pending
);

    localparam longint FX_ONE        = longint'(1) << FRAC_BITS;
    localparam longint FX_THIRD      = FX_ONE / 3;
    localparam longint FX_SIXTH      = FX_ONE / 6;
    localparam longint FX_HALF       = FX_ONE / 2;
    localparam longint FX_TWO_THIRDS = (2 * FX_ONE) / 3;
    localparam int     REPORT_LIMIT  = 10;

    shift_t shift_now;
    pixel_t expected_pixels[$];
    pixel_t want;
    int     fails;

    // floor square root, one result bit per pass
    function automatic longint unsigned root_floor(input longint unsigned x);
        longint unsigned rem;
        longint unsigned root;
        longint unsigned probe;
        rem   = x;
        root  = 0;
        probe = 64'h4000_0000_0000_0000;
        while (probe > rem)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (rem >= root + probe)
            begin
                rem  = rem - (root + probe);
                root = (root >> 1) + probe;
            end
            else
                root = root >> 1;
            probe = probe >> 2;
        end
        return root;
    endfunction

    // piecewise linear hsl component for one phase, single wrap
    function automatic longint hue_level(input longint phase);
        longint t;
        t = phase;
        if (t < 0)
            t = t + FX_ONE;
        if (t > FX_ONE)
            t = t - FX_ONE;
        if (t < FX_SIXTH)
            return 6 * t;
        if (t < FX_HALF)
            return FX_ONE;
        if (t < FX_TWO_THIRDS)
            return 6 * (FX_TWO_THIRDS - t);
        return 0;
    endfunction

    function automatic chan_t channel_byte(input longint level, input longint unsigned scale);
        longint unsigned level_u;
        longint unsigned scaled;
        longint unsigned byte_val;
        level_u  = (level < 0) ? 64'd0 : 64'(level);
        scaled   = (level_u * scale) >> FRAC_BITS;
        byte_val = (scaled * 255) >> FRAC_BITS;
        return (byte_val > 255) ? CHAN_MAX : chan_t'(byte_val);
    endfunction

    function automatic pixel_t colormap_pixel(input logic [MAG_BITS-1:0] mag,
                                              input shift_t shift);
        longint unsigned level;
        longint unsigned hue;
        longint unsigned scale;
        pixel_t px;
        level = 64'(mag);
        level = (level << FRAC_BITS) >> shift;
        if (level > 4 * FX_ONE)
            level = 4 * FX_ONE;
        hue   = root_floor(level << FRAC_BITS);
        scale = root_floor(hue << FRAC_BITS);
        px.red   = channel_byte(hue_level(longint'(hue) + FX_THIRD), scale);
        px.green = channel_byte(hue_level(longint'(hue)), scale);
        px.blue  = channel_byte(hue_level(longint'(hue) - FX_THIRD), scale);
        return px;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_now <= SHIFT_RESET;
            expected_pixels.delete();
            fails = 0;
            mismatch_count <= 0;
            pixels_pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                shift_now <= cfg_data;
            if (in_valid && !in_stall)
                expected_pixels.push_back(colormap_pixel(magnitude, shift_now));
            if (out_valid && !out_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    fails++;
                    if (fails <= REPORT_LIMIT)
                        $display("unexpected pixel transfer at %0t: r=%0d g=%0d b=%0d a=%0d",
                                 $time, red, green, blue, alpha);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (red !== want.red || green !== want.green || blue !== want.blue
                        || alpha !== ALPHA_OPAQUE)
                    begin
                        fails++;
                        if (fails <= REPORT_LIMIT)
                            $display("pixel mismatch at %0t: expected r=%0d g=%0d b=%0d a=%0d, got r=%0d g=%0d b=%0d a=%0d",
                                     $time, want.red, want.green, want.blue, ALPHA_OPAQUE,
                                     red, green, blue, alpha);
                    end
                end
            end
            mismatch_count <= fails;
            pixels_pending <= expected_pixels.size();
        end
    end

endmodule

### bench/spectrogram_pixel_colormap_test.sv
// testbench top: drives magnitudes and shift settings into the colormap and gives the verdict
`timescale 1ns / 100ps

module spectrogram_pixel_colormap_test;
    import spc_pkg::*;

    localparam int MAG_BITS     = 24;
    localparam int FRAC_BITS    = 12;
    // pipeline depth: input register, both square root chains, color stages and output register
    localparam int LATENCY      = 2 * FRAC_BITS + 8;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 500;
    localparam int PHASES       = 8;
    // long enough for the pipeline and its skid entry to fill up
    localparam int LONG_HOLD    = 300;
    localparam longint unsigned MAG_MAX = (longint'(1) << MAG_BITS) - 1;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [MAG_BITS-1:0] magnitude;
    logic                out_valid;
    logic                out_stall;
    chan_t               red;
    chan_t               green;
    chan_t               blue;
    chan_t               alpha;
    logic                cfg_valid;
    logic                cfg_ready;
    shift_t              cfg_data;

    int   mismatch_count;
    int   pixels_pending;
    int   cycle_count     = 0;
    int   stalled_cycles  = 0;
    int   magnitudes_sent = 0;
    int   shift_writes    = 0;
    logic hold_request    = 1'b0;
    logic hold_done       = 1'b0;

    // directed magnitudes at the reset shift of 10: zero, tiny values, values around
    // v = 1 (1024) and v = 2 (4096, where the hue clamp starts) and the full-scale value
    int unsigned reset_shift_mags[16] = '{0, 1, 2, 16, 100, 300, 512, 1023, 1024, 1500,
                                          2048, 3000, 4095, 4096, 4097, 16777215};
    // shift settings of the random phases; the last ones are drawn at random
    shift_t      phase_shifts[6] = '{5'd20, 5'd0, 5'd31, 5'd10, 5'd21, 5'd5};

    spectrogram_pixel_colormap #(
        .MAG_BITS  (MAG_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .magnitude (magnitude),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .alpha     (alpha),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    pixel_checker #(
        .MAG_BITS  (MAG_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) pixel_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .magnitude      (magnitude),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .alpha          (alpha),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pixels_pending (pixels_pending)
    );

    always #10 clk = ~clk;

    // cycle limit and a count of cycles where the block pushed back on its input
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (in_valid && in_stall)
            stalled_cycles <= stalled_cycles + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL spectrogram_pixel_colormap");
            $finish;
        end
    end

    // one magnitude transfer; valid stays high when the next call follows at once
    task automatic send_magnitude(input logic [MAG_BITS-1:0] value);
        @(negedge clk);
        in_valid  <= 1'b1;
        magnitude <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        magnitudes_sent++;
    endtask

    // sender gap, payload scrambled while nothing is offered
    task automatic rest_input(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            in_valid  <= 1'b0;
            magnitude <= MAG_BITS'($urandom);
        end
    endtask

    // stop offering and wait until every predicted pixel has come out
    task automatic drain_pixels;
        @(negedge clk);
        in_valid <= 1'b0;
        while (pixels_pending != 0)
            @(negedge clk);
    endtask

    // shift is only changed with the pipeline empty
    task automatic write_shift(input shift_t value);
        drain_pixels();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        shift_writes++;
    endtask

    // most magnitudes land where the normalized value is below about 5, so the hue
    // sweeps all three color ramps and the channel saturation; the rest are raw
    // 24-bit values, single-bit and single-zero patterns, full scale and zero
    function automatic logic [MAG_BITS-1:0] pick_magnitude(input shift_t shift);
        longint unsigned span;
        int              r;
        int unsigned     bitpos;
        r      = $urandom_range(0, 99);
        bitpos = $urandom_range(0, MAG_BITS - 1);
        span   = longint'(5) << shift;
        if (span > MAG_MAX)
            span = MAG_MAX;
        if (r < 65)
            return MAG_BITS'($urandom_range(0, 32'(span)));
        if (r < 85)
            return MAG_BITS'($urandom);
        if (r < 91)
            return MAG_BITS'(1 << bitpos);
        if (r < 97)
            return MAG_BITS'(~(1 << bitpos));
        return (r < 99) ? MAG_MAX[MAG_BITS-1:0] : '0;
    endfunction

    // receiver: random stalls, mostly short, a few long, stretches with no stall, and
    // one long hold-off once the sender asks for it so the block fills up
    initial
    begin
        int   r;
        int   len;
        logic stall_val;
        out_stall = 1'b0;
        forever
        begin
            r = $urandom_range(0, 99);
            if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                stall_val = 1'b1;
                len       = LONG_HOLD;
            end
            else if (r < 15)
            begin
                stall_val = 1'b1;
                len       = $urandom_range(1, 3);
            end
            else if (r < 20)
            begin
                stall_val = 1'b1;
                len       = $urandom_range(10, 40);
            end
            else if (r < 25)
            begin
                stall_val = 1'b0;
                len       = $urandom_range(50, 150);
            end
            else
            begin
                stall_val = 1'b0;
                len       = $urandom_range(1, 6);
            end
            repeat (len)
            begin
                @(negedge clk);
                out_stall <= stall_val;
                // start the long hold-off right away while the sender is still busy
                if (hold_request && !hold_done)
                    break;
            end
        end
    end

    // sender: reset, directed magnitudes, then random phases at several shift settings
    initial
    begin
        int     p;
        int     k;
        int     n;
        int     r;
        shift_t next_shift;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        magnitude = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset shift of 10, no write yet
        foreach (reset_shift_mags[k])
            send_magnitude(MAG_BITS'(reset_shift_mags[k]));

        // no normalization: magnitude 0..5 hits v = 0, 1, sqrt 2, sqrt 3, 2 and the clamp
        write_shift(5'd0);
        for (k = 0; k < 6; k++)
            send_magnitude(MAG_BITS'(k));

        // shift above the useful range just shifts further
        write_shift(5'd31);
        send_magnitude(MAG_MAX[MAG_BITS-1:0]);
        send_magnitude(24'h800000);

        for (p = 0; p < PHASES; p++)
        begin
            next_shift = (p < 6) ? phase_shifts[p] : shift_t'($urandom_range(0, 31));
            write_shift(next_shift);
            n = RANDOM_ITEMS / PHASES + $urandom_range(0, 8) - 4;
            for (k = 0; k < n; k++)
            begin
                // long receiver hold-off early in the first random phase
                if (p == 0 && k == 20)
                    hold_request = 1'b1;
                r = $urandom_range(0, 99);
                // no drain in the first phase so the sender keeps offering during the hold
                if (r == 0 && p != 0)
                    drain_pixels();
                else if (r < 30)
                    rest_input($urandom_range(1, 3));
                else if (r < 35)
                    rest_input($urandom_range(10, 40));
                send_magnitude(pick_magnitude(next_shift));
            end
        end

        drain_pixels();
        repeat (LATENCY + 8)
            @(posedge clk);

        $display("covered %0d magnitudes over %0d shift writes (0, 31, beyond-range and random)",
                 magnitudes_sent, shift_writes);
        $display("output held off %0d cycles once; input pushed back on %0d cycles",
                 LONG_HOLD, stalled_cycles);
        if (mismatch_count == 0 && pixels_pending == 0)
            $display("PASS spectrogram_pixel_colormap");
        else
            $display("FAIL spectrogram_pixel_colormap");
        $finish;
    end

endmodule
